### rtl/wssm_pkg.sv
// ----------------------------------------------------------------------------
// Wheel slip and stall monitor package
// Shared types, register indexes, operation codes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wssm_pkg;

  localparam int NumChannels = 3;
  localparam int ChIdxW      = $clog2(NumChannels);

  localparam logic [1:0] OpCurrent  = 2'd0;
  localparam logic [1:0] OpSpeed    = 2'd1;
  localparam logic [1:0] OpEvaluate = 2'd2;

  localparam logic [1:0] ReasonNormal    = 2'd0;
  localparam logic [1:0] ReasonStall     = 2'd1;
  localparam logic [1:0] ReasonNoCurrent = 2'd2;
  localparam logic [1:0] ReasonImbalance = 2'd3;

  localparam logic [2:0] RegCurrentPerSpeed = 3'd0;
  localparam logic [2:0] RegStallThreshold  = 3'd1;
  localparam logic [2:0] RegIdleThreshold   = 3'd2;
  localparam logic [2:0] RegScaleFloor      = 3'd3;
  localparam logic [2:0] RegScaleCeiling    = 3'd4;

  localparam logic [15:0] CurrentPerSpeedRst = 16'd512;
  localparam logic [15:0] StallThresholdRst  = 16'd1408;
  localparam logic [15:0] IdleThresholdRst   = 16'd77;
  localparam logic [15:0] ScaleFloorRst      = 16'd256;
  localparam logic [15:0] ScaleCeilingRst    = 16'd3840;

  // A speed above 0.05 in Q8.8 is a raw value above 12.
  localparam logic [16:0] SpeedMinRaw    = 17'd12;
  // An expected current above 0.1 in Q8.8 is a raw value above 25.
  localparam logic [15:0] ExpectedMinRaw = 16'd25;

  localparam logic signed [15:0] LowStart = 16'sd32767;

  typedef struct packed {
    logic done;
    logic rem_nonzero;
  } div_status_t;

endpackage

`default_nettype wire

### rtl/wssm_div.sv
// ----------------------------------------------------------------------------
// Wheel slip and stall monitor divider
// Restoring divider, one quotient bit per cycle, for a 32 bit dividend whose
// quotient is known to fit in 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module wssm_div
  import wssm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [17:0] divisor_i,
  output div_status_t      status_o,
  output logic [15:0]      quotient_o
);

  logic        running_q, running_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [18:0] rem_q, rem_d;
  logic [15:0] dvd_q, dvd_d;
  logic [15:0] quo_q, quo_d;
  logic [18:0] trial;
  logic [18:0] diff;
  logic        fits;

  assign trial = {rem_q[17:0], dvd_q[15]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    quo_d     = quo_q;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = '0;
      rem_d     = {3'b000, dividend_i[31:16]};
      dvd_d     = dividend_i[15:0];
    end else if (running_q) begin
      rem_d = fits ? diff : trial;
      quo_d = {quo_q[14:0], fits};
      dvd_d = {dvd_q[14:0], 1'b0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign status_o.done        = done_q;
  assign status_o.rem_nonzero = rem_q != '0;
  assign quotient_o           = quo_q;

endmodule

`default_nettype wire

### rtl/wheel_slip_stall_monitor_unit.sv
// ----------------------------------------------------------------------------
// Wheel slip and stall monitor
// Tracks motor currents and commanded speed and, on an evaluate tick after every
// channel has a sample, gives an odometry trust scale with a reason code.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Word
//   in       input      in_valid_i/in_stall_o   operation, channel, sample value
//   out      output     out_valid_o/out_stall_i trust scale, reason code
//   cfg      input      cfg_valid_i/cfg_ready_o register index, write data
//
// An evaluate tick scans the channels one per cycle, then uses one shared
// multiplier; a partial imbalance uses it a second time and then runs a
// serial divider. The input stalls while an evaluation runs and while its
// result waits for the output register to free up. Reset restores the
// register defaults and clears all channels and the commanded speed.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_slip_stall_monitor_unit
  import wssm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [1:0]  channel_i,
  input  wire logic [15:0] sample_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      trust_scale_o,
  output logic [1:0]       reason_code_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StScan   = 8'b0000_0010,
    StMul    = 8'b0000_0100,
    StDecide = 8'b0000_1000,
    StMul2   = 8'b0001_0000,
    StDivGo  = 8'b0010_0000,
    StDiv    = 8'b0100_0000,
    StDone   = 8'b1000_0000
  } state_e;

  localparam logic [3:0] ChLimit = 4'(NumChannels);

  state_e state_q, state_d;

  logic [15:0] cps_q, stall_thr_q, idle_thr_q, floor_q, ceil_q;

  logic signed [15:0]   cur_q [NumChannels];
  logic [NumChannels-1:0] seen_q;
  logic [16:0]          speed_q;

  logic [ChIdxW-1:0]  scan_cnt_q, scan_cnt_d;
  logic signed [15:0] peak_q, peak_d;
  logic signed [15:0] low_q, low_d;
  logic [32:0]        prod_q;
  logic [15:0]        expected_q, expected_d;
  logic [15:0]        diff_q, diff_d;
  logic [15:0]        res_scale_q, res_scale_d;
  logic [1:0]         res_reason_q, res_reason_d;

  logic        out_valid_q;
  logic [15:0] out_scale_q;
  logic [1:0]  out_reason_q;

  logic        in_acc;
  logic        ch_ok;
  logic [ChIdxW-1:0] ch_idx;
  logic [16:0] sample_ext;
  logic [16:0] speed_mag;

  logic signed [15:0] scan_cur;
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] mul_p;
  logic [16:0] span;
  logic        span_neg;
  logic [15:0] span_mag;

  logic [15:0] expected_sat;
  logic [16:0] diff_wide;
  logic [17:0] diff_x2;
  logic [17:0] exp_x3;
  logic [17:0] exp_x4;

  logic        div_start;
  div_status_t div_status;
  logic [15:0] div_quo;

  logic out_load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != StIdle;
  assign in_acc      = in_valid_i && (state_q == StIdle);

  assign ch_ok      = {2'b00, channel_i} < ChLimit;
  assign ch_idx     = ChIdxW'(channel_i);
  assign sample_ext = {sample_value_i[15], sample_value_i};
  assign speed_mag  = sample_value_i[15] ? (17'd0 - sample_ext) : sample_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q       <= CurrentPerSpeedRst;
      stall_thr_q <= StallThresholdRst;
      idle_thr_q  <= IdleThresholdRst;
      floor_q     <= ScaleFloorRst;
      ceil_q      <= ScaleCeilingRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCurrentPerSpeed: cps_q       <= cfg_data_i;
        RegStallThreshold:  stall_thr_q <= cfg_data_i;
        RegIdleThreshold:   idle_thr_q  <= cfg_data_i;
        RegScaleFloor:      floor_q     <= cfg_data_i;
        RegScaleCeiling:    ceil_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        cur_q[i] <= '0;
      end
      seen_q  <= '0;
      speed_q <= '0;
    end else if (in_acc) begin
      if (operation_i == OpCurrent && ch_ok) begin
        cur_q[ch_idx]  <= sample_value_i;
        seen_q[ch_idx] <= 1'b1;
      end else if (operation_i == OpSpeed) begin
        speed_q <= speed_mag;
      end
    end
  end

  assign scan_cur = cur_q[scan_cnt_q];

  assign span     = {1'b0, ceil_q} - {1'b0, floor_q};
  assign span_neg = span[16];
  assign span_mag = span_neg ? (floor_q - ceil_q) : span[15:0];

  assign mul_a = (state_q == StMul2) ? {1'b0, span_mag} : speed_q;
  assign mul_b = (state_q == StMul2) ? diff_q : cps_q;
  assign mul_p = {16'd0, mul_a} * {17'd0, mul_b};

  assign expected_sat = (prod_q[32:24] != '0) ? 16'hFFFF : prod_q[23:8];
  assign diff_wide    = {peak_q[15], peak_q} - {low_q[15], low_q};
  assign diff_x2      = {1'b0, diff_wide[15:0], 1'b0};
  assign exp_x3       = {1'b0, expected_sat, 1'b0} + {2'b00, expected_sat};
  assign exp_x4       = {expected_sat, 2'b00};

  assign div_start = state_q == StDivGo;
  assign out_load  = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    scan_cnt_d   = scan_cnt_q;
    peak_d       = peak_q;
    low_d        = low_q;
    expected_d   = expected_q;
    diff_d       = diff_q;
    res_scale_d  = res_scale_q;
    res_reason_d = res_reason_q;
    case (state_q)
      StIdle: begin
        if (in_acc && operation_i == OpEvaluate && (&seen_q)) begin
          scan_cnt_d = '0;
          peak_d     = '0;
          low_d      = LowStart;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (scan_cur > peak_q) begin
          peak_d = scan_cur;
        end
        if (scan_cur < low_q) begin
          low_d = scan_cur;
        end
        if (scan_cnt_q == ChIdxW'(NumChannels - 1)) begin
          state_d = StMul;
        end else begin
          scan_cnt_d = scan_cnt_q + ChIdxW'(1);
        end
      end
      StMul: begin
        state_d = StDecide;
      end
      StDecide: begin
        expected_d = expected_sat;
        diff_d     = diff_wide[15:0];
        state_d    = StDone;
        if (peak_q[15:0] > stall_thr_q) begin
          res_scale_d  = ceil_q;
          res_reason_d = ReasonStall;
        end else if (speed_q > SpeedMinRaw && peak_q[15:0] < idle_thr_q) begin
          res_scale_d  = ceil_q;
          res_reason_d = ReasonNoCurrent;
        end else if (expected_sat > ExpectedMinRaw && diff_x2 > exp_x3) begin
          res_reason_d = ReasonImbalance;
          if ({2'b00, diff_wide[15:0]} >= exp_x4) begin
            res_scale_d = ceil_q;
          end else begin
            state_d = StMul2;
          end
        end else begin
          res_scale_d  = floor_q;
          res_reason_d = ReasonNormal;
        end
      end
      StMul2: begin
        state_d = StDivGo;
      end
      StDivGo: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_status.done) begin
          if (span_neg) begin
            res_scale_d = floor_q - div_quo - {15'd0, div_status.rem_nonzero};
          end else begin
            res_scale_d = floor_q + div_quo;
          end
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_cnt_q   <= scan_cnt_d;
    peak_q       <= peak_d;
    low_q        <= low_d;
    expected_q   <= expected_d;
    diff_q       <= diff_d;
    res_scale_q  <= res_scale_d;
    res_reason_q <= res_reason_d;
    if (state_q == StMul || state_q == StMul2) begin
      prod_q <= mul_p;
    end
    if (out_load) begin
      out_scale_q  <= res_scale_q;
      out_reason_q <= res_reason_q;
    end
  end

  wssm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[31:0]),
    .divisor_i  ({expected_q, 2'b00}),
    .status_o   (div_status),
    .quotient_o (div_quo)
  );

  assign out_valid_o   = out_valid_q;
  assign trust_scale_o = out_scale_q;
  assign reason_code_o = out_reason_q;

endmodule

`default_nettype wire

### rtl/wssm_checker.sv
// ----------------------------------------------------------------------------
// Wheel slip and stall monitor checker
// Port level assertions on the monitor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module wssm_checker
  import wssm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  operation_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] trust_scale_o,
  input wire logic [1:0]  reason_code_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o
);

  // A held result word keeps its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(trust_scale_o) &&
      $stable(reason_code_o))
    else $error("held result word changed");

  // Samples, speed commands and unknown operations leave the input unstalled in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i != OpEvaluate |=> !in_stall_o)
    else $error("non-evaluate word kept the input stalled");

  // A new result only appears at the end of an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an evaluation");

  // The configuration port never back-pressures.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write was refused");

endmodule

bind wheel_slip_stall_monitor_unit wssm_checker u_wssm_checker (.*);

`default_nettype wire

### bench/wheel_slip_stall_monitor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel slip and stall monitor testbench
// Drives current samples, speed commands, evaluate ticks and unused operations
// with random idling on the input and output channels across several register
// settings. Trust words are checked against a built-in predictor or a fixed plan.
// ----------------------------------------------------------------------------

module wheel_slip_stall_monitor_unit_test;
  import wssm_pkg::*;

  localparam int SettleCycles  = 48;
  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseItems    = 125;
  localparam int MaxIdle       = 17;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [15:0] scale;
    logic [1:0]  reason;
  } trust_word_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  lane;
    logic [15:0] value;
    logic        fixed;
    logic [15:0] scale;
    logic [1:0]  reason;
  } plan_row_t;

  localparam plan_row_t OpeningPlan [26] = '{
    '{OpEvaluate, 2'd0, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpCurrent,  2'd0, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpCurrent,  2'd1, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd1, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpCurrent,  2'd3, 16'd1000,    1'b0, 16'd0,           ReasonNormal},
    '{OpUnused,   2'd2, 16'hFFFF,    1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd2, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpCurrent,  2'd2, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd0, 16'd0,       1'b1, ScaleFloorRst,   ReasonNormal},
    '{OpCurrent,  2'd0, 16'h7FFF,    1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd0, 16'd0,       1'b1, ScaleCeilingRst, ReasonStall},
    '{OpCurrent,  2'd0, 16'h8000,    1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd0, 16'd0,       1'b1, ScaleFloorRst,   ReasonNormal},
    '{OpSpeed,    2'd0, 16'h8000,    1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd0, 16'd0,       1'b1, ScaleCeilingRst, ReasonNoCurrent},
    '{OpSpeed,    2'd0, 16'd12,      1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd0, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpSpeed,    2'd0, 16'd13,      1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd0, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpSpeed,    2'd0, 16'd256,     1'b0, 16'd0,           ReasonNormal},
    '{OpCurrent,  2'd1, 16'd1000,    1'b0, 16'd0,           ReasonNormal},
    '{OpCurrent,  2'd2, 16'd500,     1'b0, 16'd0,           ReasonNormal},
    '{OpCurrent,  2'd0, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd0, 16'd0,       1'b0, 16'd0,           ReasonNormal},
    '{OpCurrent,  2'd0, -16'sd1100,  1'b0, 16'd0,           ReasonNormal},
    '{OpEvaluate, 2'd0, 16'd0,       1'b0, 16'd0,           ReasonNormal}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i    = OpCurrent;
  logic [1:0]  channel_i      = 2'd0;
  logic [15:0] sample_value_i = 16'd0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [15:0] trust_scale_o;
  logic [1:0]  reason_code_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i    = RegCurrentPerSpeed;
  logic [15:0] cfg_data_i     = 16'd0;

  logic signed [15:0]     model_current [NumChannels];
  logic [NumChannels-1:0] model_seen;
  logic [16:0]            model_speed;
  logic [15:0]            reg_cps;
  logic [15:0]            reg_stall;
  logic [15:0]            reg_idle;
  logic [15:0]            reg_floor;
  logic [15:0]            reg_ceil;

  trust_word_t awaited_trust [$];
  logic        plan_fixed = 1'b0;
  trust_word_t plan_word  = '0;
  logic        hold_request = 1'b0;
  int          quiet_left   = 0;
  int          failures     = 0;
  int          live_items   = 0;
  int          results_checked = 0;
  int          settings_used   = 1;
  int          quiet_cycles    = 0;
  int          reason_count [4] = '{0, 0, 0, 0};

  wheel_slip_stall_monitor_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .channel_i      (channel_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trust_scale_o  (trust_scale_o),
    .reason_code_o  (reason_code_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NumChannels; i++) model_current[i] = '0;
    model_seen  = '0;
    model_speed = '0;
    reg_cps     = CurrentPerSpeedRst;
    reg_stall   = StallThresholdRst;
    reg_idle    = IdleThresholdRst;
    reg_floor   = ScaleFloorRst;
    reg_ceil    = ScaleCeilingRst;
  end

  function automatic trust_word_t assess_trust();
    longint peak, low, prod, expected, diff, span, num;
    int idx;
    trust_word_t word;
    peak = 0;
    low  = 32767;
    for (idx = 0; idx < NumChannels; idx++) begin
      if (longint'(model_current[idx]) > peak) peak = longint'(model_current[idx]);
      if (longint'(model_current[idx]) < low) low = longint'(model_current[idx]);
    end
    prod = (longint'(model_speed) * longint'(reg_cps)) >>> 8;
    expected = (prod > 65535) ? 65535 : prod;
    word.scale  = reg_floor;
    word.reason = ReasonNormal;
    if (peak > longint'(reg_stall)) begin
      word.scale  = reg_ceil;
      word.reason = ReasonStall;
    end else if (longint'(model_speed) * 20 > 256 && peak < longint'(reg_idle)) begin
      word.scale  = reg_ceil;
      word.reason = ReasonNoCurrent;
    end else if (expected * 10 > 256) begin
      diff = peak - low;
      if (diff * 2 > expected * 3) begin
        if (diff >= expected * 4) begin
          word.scale = reg_ceil;
        end else begin
          span = longint'(reg_ceil) - longint'(reg_floor);
          num  = longint'(reg_floor) * 4 * expected + span * diff;
          word.scale = 16'(num / (4 * expected));
        end
        word.reason = ReasonImbalance;
      end
    end
    return word;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    trust_word_t predicted;
    trust_word_t oldest;
    int magnitude;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o === 1'b1) begin
        case (cfg_index_i)
          RegCurrentPerSpeed: reg_cps   = cfg_data_i;
          RegStallThreshold:  reg_stall = cfg_data_i;
          RegIdleThreshold:   reg_idle  = cfg_data_i;
          RegScaleFloor:      reg_floor = cfg_data_i;
          RegScaleCeiling:    reg_ceil  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_stall_o === 1'b0) begin
        case (operation_i)
          OpCurrent: begin
            if (channel_i < NumChannels) begin
              model_current[channel_i] = sample_value_i;
              model_seen[channel_i]    = 1'b1;
            end
          end
          OpSpeed: begin
            magnitude = int'($signed(sample_value_i));
            if (magnitude < 0) magnitude = -magnitude;
            model_speed = 17'(magnitude);
          end
          OpEvaluate: begin
            if (&model_seen) begin
              predicted = assess_trust();
              if (plan_fixed) predicted = plan_word;
              awaited_trust = {awaited_trust, predicted};
            end
          end
          default: ;
        endcase
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (awaited_trust.size() == 0) begin
          failures++;
          $error("unexpected trust word: trust_scale %0d, reason_code %0d",
                 trust_scale_o, reason_code_o);
        end else begin
          oldest = awaited_trust.pop_front();
          results_checked++;
          reason_count[oldest.reason]++;
          if (trust_scale_o !== oldest.scale) begin
            failures++;
            $error("trust_scale: expected %0d, got %0d", oldest.scale, trust_scale_o);
          end
          if (reason_code_o !== oldest.reason) begin
            failures++;
            $error("reason_code: expected %0d, got %0d", oldest.reason, reason_code_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("No word moved for %0d cycles.", WatchdogLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : receiver
    int stall_left;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        out_stall_i = 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end
      stall_left = (quiet_left > 0) ? 0 : $urandom_range(0, MaxIdle);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        repeat (stall_left) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [1:0] lane,
                           input logic [15:0] value);
    int gap;
    gap = (quiet_left > 0) ? 0 : $urandom_range(0, MaxIdle);
    if (quiet_left > 0) quiet_left--;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i    = op;
    channel_i      = lane;
    sample_value_i = value;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
    if (!(op == OpUnused || (op == OpCurrent && lane >= NumChannels))) live_items++;
  endtask

  task automatic settle_idle();
    in_valid_i = 1'b0;
    while (awaited_trust.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_index_i = index;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] cps, input logic [15:0] stall,
                                input logic [15:0] idle, input logic [15:0] floor_v,
                                input logic [15:0] ceil_v);
    settle_idle();
    write_reg(RegCurrentPerSpeed, cps);
    write_reg(RegStallThreshold, stall);
    write_reg(RegIdleThreshold, idle);
    write_reg(RegScaleFloor, floor_v);
    write_reg(RegScaleCeiling, ceil_v);
    cfg_valid_i = 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_current();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 400));
      2:       return 16'($urandom_range(0, 3000));
      default: return 16'(int'($urandom_range(0, 3000)) - 1500);
    endcase
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 40));
      2:       return 16'($urandom_range(0, 1024));
      default: return 16'(-int'($urandom_range(0, 1024)));
    endcase
  endfunction

  // Most bursts refresh the channels and then evaluate; the rest is noise.
  task automatic drive_random_items(input int count, input bit pause_midway);
    int target, midpoint, lane;
    target   = live_items + count;
    midpoint = live_items + count / 2;
    while (live_items < target) begin
      if (pause_midway && live_items >= midpoint) begin
        pause_midway = 1'b0;
        settle_idle();
      end
      if (quiet_left == 0 && $urandom_range(0, 19) == 0) quiet_left = 30;
      if ($urandom_range(0, 9) < 8) begin
        for (lane = 0; lane < NumChannels; lane++) begin
          if ($urandom_range(0, 4) != 0) send_word(OpCurrent, 2'(lane), pick_current());
        end
        if ($urandom_range(0, 2) == 0) begin
          send_word(OpSpeed, 2'($urandom_range(0, 3)), pick_speed());
        end
        send_word(OpEvaluate, 2'($urandom_range(0, 3)), 16'($urandom));
      end else begin
        send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int row;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (row = 0; row < 26; row++) begin
      plan_fixed = OpeningPlan[row].fixed;
      plan_word  = '{scale: OpeningPlan[row].scale, reason: OpeningPlan[row].reason};
      send_word(OpeningPlan[row].op, OpeningPlan[row].lane, OpeningPlan[row].value);
    end
    plan_fixed = 1'b0;
    drive_random_items(PhaseItems, 1'b0);

    apply_settings(16'($urandom_range(256, 1024)), 16'($urandom_range(800, 3000)),
                   16'($urandom_range(0, 300)), 16'($urandom_range(0, 1000)),
                   16'($urandom_range(1000, 8000)));
    hold_request = 1'b1;
    quiet_left   = 40;
    drive_random_items(PhaseItems, 1'b0);

    apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    drive_random_items(PhaseItems, 1'b1);

    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    drive_random_items(PhaseItems, 1'b0);

    // The ceiling sits below the floor here.
    apply_settings(16'd384, 16'd2000, 16'd100, 16'd3000, 16'd200);
    drive_random_items(PhaseItems, 1'b0);

    apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
    drive_random_items(PhaseItems, 1'b0);

    settle_idle();
    if (awaited_trust.size() != 0) begin
      failures++;
      $error("%0d expected trust words never arrived", awaited_trust.size());
    end
    $display("Checked %0d trust words: normal %0d, stall %0d, no current %0d, imbalance %0d,",
             results_checked, reason_count[ReasonNormal], reason_count[ReasonStall],
             reason_count[ReasonNoCurrent], reason_count[ReasonImbalance]);
    $display("from %0d input words under %0d register settings.", live_items, settings_used);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### wheel_slip_stall_monitor_unit.f
rtl/wssm_pkg.sv
rtl/wssm_div.sv
rtl/wheel_slip_stall_monitor_unit.sv
rtl/wssm_checker.sv
bench/wheel_slip_stall_monitor_unit_test.sv
